@@ src/assert_macros.svh @@
// Assertion macros used by the free list datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fbfl_pkg.sv @@
// Types and constants of the fixed block free list.
`timescale 1ns / 1ps
`default_nettype none
package fbfl_pkg;

   localparam int ACT_W = 2;
   localparam int IDX_W = 10;
   localparam int STAT_W = 2;
   localparam int CNT_W = 11;
   localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      RSP_ALLOCATED = 2'd0,
      RSP_EXHAUSTED = 2'd1,
      RSP_DONE      = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       mem_rd;
      logic       free_wr;
      logic       clear_init;
      logic       clear_wr;
      logic       head_end;
      logic       head_pop;
      logic       rsp_load;
      logic       rsp_give_head;
      status_type rsp_code;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             head_empty;
      logic             idx_ok;
      logic             count_zero;
      logic             clear_last;
      logic             slot_free;
   } sts_type;

endpackage
`default_nettype wire

@@ src/fbfl_req_if.sv @@
// Request channel: one action beat.
`timescale 1ns / 1ps
`default_nettype none
interface fbfl_req_if;
   logic                          valid;
   logic                          ready;
   logic [fbfl_pkg::ACT_W-1:0]    action;
   logic [fbfl_pkg::IDX_W-1:0]    free_index;

   modport source (output valid, output action, output free_index, input ready);
   modport sink (input valid, input action, input free_index, output ready);
endinterface
`default_nettype wire

@@ src/fbfl_rsp_if.sv @@
// Response channel: one result beat.
`timescale 1ns / 1ps
`default_nettype none
interface fbfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbfl_pkg::IDX_W-1:0]    block_index;
   logic [fbfl_pkg::STAT_W-1:0]   status;

   modport source (output valid, output block_index, output status, input ready);
   modport sink (input valid, input block_index, input status, output ready);
endinterface
`default_nettype wire

@@ src/fixed_block_free_list_top.sv @@
// Top level of the fixed block free list allocator.
`timescale 1ns / 1ps
`default_nettype none
// Allocator for POOL_DEPTH equal-size blocks kept on a LIFO free list in a
// single-port link memory. Each request beat is allocate, free or clear and
// yields exactly one response beat, held in an output register; the next
// request is taken no earlier than the cycle in which the waiting result
// leaves. Free, the unused action and an allocate from an exhausted pool are
// answered straight from the idle state; any other allocate first waits for
// the registered read of the link memory; clear chains min(count, POOL_DEPTH)
// links, as it writes one link per cycle through the memory's write port (a
// count of zero only empties the list). After reset an initial clear of
// min(1024, POOL_DEPTH) links runs with req ready low; csr writes are taken
// throughout. A written count applies from the next clear.
module fixed_block_free_list_top #(
   parameter int POOL_DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   fbfl_req_if.sink                        req,
   fbfl_rsp_if.source                      rsp,
   input  wire logic                       csr_wr_en,
   input  wire logic [fbfl_pkg::CNT_W-1:0] csr_wr_data
);

   fbfl_pkg::cmd_type cmd;
   fbfl_pkg::sts_type sts;

   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbfl_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req.action),
      .req_free_index  (req.free_index),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_block_index (rsp.block_index),
      .rsp_status      (rsp.status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

endmodule
`default_nettype wire

@@ src/fbfl_datapath.sv @@
// Datapath: link memory, head pointer, clear counter, count register, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fbfl_datapath #(
   parameter int POOL_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fbfl_pkg::cmd_type             cmd,
   output fbfl_pkg::sts_type                  sts,
   input  wire logic [fbfl_pkg::ACT_W-1:0]    req_action,
   input  wire logic [fbfl_pkg::IDX_W-1:0]    req_free_index,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [fbfl_pkg::IDX_W-1:0]         rsp_block_index,
   output logic [fbfl_pkg::STAT_W-1:0]        rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [fbfl_pkg::CNT_W-1:0]    csr_wr_data
);

   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int PTR_W = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W = (PTR_W > fbfl_pkg::CNT_W) ? PTR_W : fbfl_pkg::CNT_W;
   localparam int INIT_N = (int'(fbfl_pkg::CNT_RESET) > POOL_DEPTH) ?
                           POOL_DEPTH : int'(fbfl_pkg::CNT_RESET);
   localparam logic [PTR_W-1:0] LIST_END = PTR_W'(POOL_DEPTH);

   logic [PTR_W-1:0]            link_mem [POOL_DEPTH];
   logic [PTR_W-1:0]            rd_data_ff;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [ADDR_W-1:0]           ctr_ff, ctr_in;
   logic [ADDR_W-1:0]           last_ff, last_in;
   logic [fbfl_pkg::CNT_W-1:0]  count_ff;
   logic                        rsp_valid_ff;
   logic [fbfl_pkg::IDX_W-1:0]  rsp_index_ff;
   logic [fbfl_pkg::STAT_W-1:0] rsp_status_ff;

   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  cnt_clamp;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [PTR_W-1:0]  wr_data;

   always_comb begin
      cnt_ext = CMP_W'(count_ff);
      cnt_clamp = (cnt_ext > CMP_W'(POOL_DEPTH)) ? CMP_W'(POOL_DEPTH) : cnt_ext;
      last_in = ADDR_W'(cnt_clamp - CMP_W'(1));

      sts.act = req_action;
      sts.head_empty = (head_ff == LIST_END);
      sts.idx_ok = (CMP_W'(req_free_index) < CMP_W'(POOL_DEPTH));
      sts.count_zero = (cnt_ext == '0);
      sts.clear_last = (ctr_ff == last_ff);
      sts.slot_free = !rsp_valid_ff || rsp_ready;

      wr_en = cmd.free_wr || cmd.clear_wr;
      if (cmd.free_wr) begin
         wr_addr = ADDR_W'(req_free_index);
         wr_data = head_ff;
      end else begin
         wr_addr = ctr_ff;
         wr_data = sts.clear_last ? LIST_END : (PTR_W'(ctr_ff) + PTR_W'(1));
      end

      head_in = head_ff;
      if (cmd.free_wr) begin
         head_in = PTR_W'(req_free_index);
      end else if (cmd.head_pop) begin
         head_in = rd_data_ff;
      end else if (cmd.head_end) begin
         head_in = LIST_END;
      end else if (cmd.clear_wr && sts.clear_last) begin
         head_in = '0;
      end

      ctr_in = ctr_ff;
      if (cmd.clear_init) begin
         ctr_in = '0;
      end else if (cmd.clear_wr) begin
         ctr_in = ctr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= link_mem[ADDR_W'(head_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         ctr_ff <= '0;
         last_ff <= ADDR_W'(INIT_N - 1);
         count_ff <= fbfl_pkg::CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         ctr_ff <= ctr_in;
         if (cmd.clear_init) begin
            last_ff <= last_in;
         end
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_index_ff <= cmd.rsp_give_head ? fbfl_pkg::IDX_W'(head_ff) : '0;
         rsp_status_ff <= cmd.rsp_code;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_status = rsp_status_ff;

   `ASSERT_ALWAYS(a_head_range, clock, reset, head_ff <= LIST_END, "head past list end")
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !cmd.rsp_load || sts.slot_free,
                  "result overwritten before taken")
   `ASSERT_NEXT(a_free_head, clock, reset, cmd.free_wr,
                head_ff == $past(PTR_W'(req_free_index)), "freed block not at head")
   `ASSERT_NEXT(a_clear_head, clock, reset, cmd.clear_wr && sts.clear_last,
                head_ff == '0, "clear did not leave block zero at head")

endmodule
`default_nettype wire

@@ src/fbfl_ctrl.sv @@
// Controller: sequences allocate, free and clear over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module fbfl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fbfl_pkg::sts_type sts,
   output fbfl_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      report_ff, report_in;
   logic      accept;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && sts.slot_free;
      accept = req_valid && req_ready;
      state_in = state_ff;
      report_in = report_ff;

      cmd.mem_rd = 1'b0;
      cmd.free_wr = 1'b0;
      cmd.clear_init = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.head_end = 1'b0;
      cmd.head_pop = 1'b0;
      cmd.rsp_load = 1'b0;
      cmd.rsp_give_head = 1'b0;
      cmd.rsp_code = fbfl_pkg::RSP_DONE;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (sts.act)
                  fbfl_pkg::ACT_ALLOC: begin
                     if (sts.head_empty) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_code = fbfl_pkg::RSP_EXHAUSTED;
                     end else begin
                        cmd.mem_rd = 1'b1;
                        state_in = S_ALLOC_WAIT;
                     end
                  end
                  fbfl_pkg::ACT_FREE: begin
                     cmd.free_wr = sts.idx_ok;
                     cmd.rsp_load = 1'b1;
                  end
                  fbfl_pkg::ACT_CLEAR: begin
                     if (sts.count_zero) begin
                        cmd.head_end = 1'b1;
                        cmd.rsp_load = 1'b1;
                     end else begin
                        cmd.clear_init = 1'b1;
                        report_in = 1'b1;
                        state_in = S_CLEAR;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC_WAIT: begin
            cmd.head_pop = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_give_head = 1'b1;
            cmd.rsp_code = fbfl_pkg::RSP_ALLOCATED;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               cmd.rsp_load = report_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         report_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         report_ff <= report_in;
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/fixed_block_free_list_top_test.sv @@
// Testbench for the fixed block free list allocator: random and directed actions vs a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_free_list_top_test;

   localparam int POOL_DEPTH = 1024;
   localparam int CNT_W = fbfl_pkg::CNT_W;
   localparam int ACT_W = fbfl_pkg::ACT_W;
   localparam int IDX_W = fbfl_pkg::IDX_W;
   localparam int STAT_W = fbfl_pkg::STAT_W;
   localparam logic [CNT_W-1:0] LIST_END = CNT_W'(POOL_DEPTH);
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS = 50;
   localparam int PHASES = 8;

   typedef struct packed {
      logic [IDX_W-1:0]     block_index;
      fbfl_pkg::status_type status;
   } alloc_result_type;

   class pool_scoreboard;
      logic [CNT_W-1:0] next_link [POOL_DEPTH];
      logic [CNT_W-1:0] head;
      logic [CNT_W-1:0] count;
      alloc_result_type due_results [$];
      int               errors;

      function new();
         count = fbfl_pkg::CNT_RESET;
         errors = 0;
         chain_pool();
      endfunction

      function void set_count(input logic [CNT_W-1:0] value);
         count = value;
      endfunction

      function void chain_pool();
         int n;
         n = (count > POOL_DEPTH) ? POOL_DEPTH : int'(count);
         if (n == 0) begin
            head = LIST_END;
         end else begin
            for (int i = 0; i < n - 1; i++) next_link[i] = CNT_W'(i + 1);
            next_link[n - 1] = LIST_END;
            head = '0;
         end
      endfunction

      function void note_action(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                output alloc_result_type res);
         res.block_index = '0;
         res.status = fbfl_pkg::RSP_DONE;
         case (act)
            fbfl_pkg::ACT_ALLOC: begin
               if (head < LIST_END) begin
                  res.block_index = head[IDX_W-1:0];
                  res.status = fbfl_pkg::RSP_ALLOCATED;
                  head = next_link[head[IDX_W-1:0]];
               end else begin
                  res.status = fbfl_pkg::RSP_EXHAUSTED;
               end
            end
            fbfl_pkg::ACT_FREE: begin
               if (CNT_W'(idx) < LIST_END) begin
                  next_link[idx] = head;
                  head = CNT_W'(idx);
               end
            end
            fbfl_pkg::ACT_CLEAR: begin
               chain_pool();
            end
            default: begin
            end
         endcase
         due_results.push_back(res);
      endfunction

      function void check_result(input logic [IDX_W-1:0] got_index,
                                 input logic [STAT_W-1:0] got_status);
         alloc_result_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, got index %0d status %0d",
                     $time, got_index, got_status);
            return;
         end
         want = due_results.pop_front();
         if (got_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, got_status);
         end
         if (got_index !== want.block_index) begin
            errors++;
            $display("%0t: block_index mismatch, expected %0d got %0d",
                     $time, want.block_index, got_index);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;
   int               send_idle_pct;
   int               recv_stall_pct;
   int               hold_requests;
   logic [IDX_W-1:0] held_blocks [$];
   pool_scoreboard   pool_sb = new();

   fbfl_req_if req_if();
   fbfl_rsp_if rsp_if();

   fixed_block_free_list_top #(.POOL_DEPTH(POOL_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_beat(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                            output alloc_result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.free_index <= idx;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pool_sb.note_action(act, idx, res);
   endtask

   task automatic apply_action(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
      alloc_result_type res;
      send_beat(act, idx, res);
      if (act == fbfl_pkg::ACT_CLEAR) held_blocks.delete();
      else if (act == fbfl_pkg::ACT_ALLOC && res.status == fbfl_pkg::RSP_ALLOCATED)
         held_blocks.push_back(res.block_index);
   endtask

   // mostly alloc / free of held blocks; noise is stray frees, unused action, clears
   task automatic random_action();
      int               roll;
      int               pos;
      logic [IDX_W-1:0] idx;
      roll = $urandom_range(99);
      idx = IDX_W'($urandom_range(POOL_DEPTH - 1));
      if (roll < 2) begin
         apply_action(fbfl_pkg::ACT_CLEAR, idx);
      end else if (roll < 5) begin
         apply_action(ACT_UNUSED, idx);
      end else if (roll < 10) begin
         apply_action(fbfl_pkg::ACT_FREE, idx);
      end else if (roll < 50 || held_blocks.size() == 0) begin
         apply_action(fbfl_pkg::ACT_ALLOC, idx);
      end else begin
         pos = $urandom_range(held_blocks.size() - 1);
         idx = held_blocks[pos];
         held_blocks.delete(pos);
         apply_action(fbfl_pkg::ACT_FREE, idx);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pool_sb.due_results.size() != 0);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pool_sb.set_count(value);
   endtask

   initial begin
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            pool_sb.check_result(rsp_if.block_index, rsp_if.status);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [CNT_W-1:0] phase_counts [PHASES];
      phase_counts = '{11'd3, 11'd1024, 11'd1, 11'd40, 11'd2047, 11'd12, 11'd0, 11'd256};
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.action <= fbfl_pkg::ACT_ALLOC;
      req_if.free_index <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full pool after reset; free of an already free block
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_FREE, 10'd0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_FREE, 10'd1023);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(ACT_UNUSED, 10'd1023);
      apply_action(fbfl_pkg::ACT_CLEAR, '0);

      // empty pool from a zero count
      wait_drained();
      write_count(11'd0);
      apply_action(fbfl_pkg::ACT_CLEAR, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_FREE, 10'd5);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);

      // count above pool depth
      wait_drained();
      write_count(11'd2047);
      apply_action(fbfl_pkg::ACT_CLEAR, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);

      // single block; free above count, twice
      wait_drained();
      write_count(11'd1);
      apply_action(fbfl_pkg::ACT_CLEAR, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_FREE, 10'd700);
      apply_action(fbfl_pkg::ACT_FREE, 10'd700);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);
      apply_action(fbfl_pkg::ACT_ALLOC, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 15;
               recv_stall_pct = 15;
            end
         endcase
         write_count(phase_counts[phase]);
         apply_action(fbfl_pkg::ACT_CLEAR, '0);
         if (phase == 0) hold_requests++;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == PHASE_ITEMS / 2) wait_drained();
            random_action();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.due_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/fbfl_pkg.sv
src/fbfl_req_if.sv
src/fbfl_rsp_if.sv
src/fbfl_datapath.sv
src/fbfl_ctrl.sv
src/fixed_block_free_list_top.sv
tb/sv/fixed_block_free_list_top_test.sv
